// ===== rtl/core/acd_pkg.sv =====
`default_nettype none

package acd_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_PAD   = 2'd1,
        ST_NO_CIPHER = 2'd2,
        ST_TOO_MANY  = 2'd3
    } t_status;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic [127:0] prev;
        logic         last;
        logic         too_many;
        logic         no_cipher;
    } t_side;

    typedef struct packed {
        logic [127:0] state;
        logic [127:0] rkey;
        t_side        side;
    } t_stage;

    localparam logic [0:255][7:0] SBOX = {
        192'h637c777bf26b6fc53001672bfed7ab76ca82c97dfa5947f0,
        192'hadd4a2af9ca472c0b7fd9326363ff7cc34a5e5f171d83115,
        192'h04c723c31896059a071280e2eb27b27509832c1a1b6e5aa0,
        192'h523bd6b329e32f8453d100ed20fcb15b6acbbe394a4c58cf,
        192'hd0efaafb434d338545f9027f503c9fa851a3408f929d38f5,
        192'hbcb6da2110fff3d2cd0c13ec5f974417c4a77e3d645d1973,
        192'h60814fdc222a908846eeb814de5e0bdbe0323a0a4906245c,
        192'hc2d3ac629195e479e7c8376d8dd54ea96c56f4ea657aae08,
        192'hba78252e1ca6b4c6e8dd741f4bbd8b8a703eb5664803f60e,
        192'h613557b986c11d9ee1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [1:10][7:0] RCON = {
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [7:0] aff_inv(input logic [7:0] x);
        return rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05;
    endfunction

    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        return SBOX[x];
    endfunction

    function automatic logic [7:0] inv_sub_byte(input logic [7:0] x);
        return aff_inv(SBOX[aff_inv(x)]);
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul4(input logic [7:0] a, input logic [3:0] c);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h00;
        p = a;
        for (int i = 0; i < 4; i++) begin
            if (c[i]) r = r ^ p;
            p = xtime(p);
        end
        return r;
    endfunction

    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] o;
        o = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                o[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8] =
                    inv_sub_byte(s[127 - 8 * (r + 4 * c) -: 8]);
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0] a0, a1, a2, a3;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            o[127 - 32 * c -: 8] = gmul4(a0, 4'd14) ^ gmul4(a1, 4'd11)
                                 ^ gmul4(a2, 4'd13) ^ gmul4(a3, 4'd9);
            o[119 - 32 * c -: 8] = gmul4(a0, 4'd9) ^ gmul4(a1, 4'd14)
                                 ^ gmul4(a2, 4'd11) ^ gmul4(a3, 4'd13);
            o[111 - 32 * c -: 8] = gmul4(a0, 4'd13) ^ gmul4(a1, 4'd9)
                                 ^ gmul4(a2, 4'd14) ^ gmul4(a3, 4'd11);
            o[103 - 32 * c -: 8] = gmul4(a0, 4'd11) ^ gmul4(a1, 4'd13)
                                 ^ gmul4(a2, 4'd9) ^ gmul4(a3, 4'd14);
        end
        return o;
    endfunction

    function automatic logic [31:0] rot_sub(input logic [31:0] w, input logic [7:0] rc);
        return {sub_byte(w[23:16]) ^ rc, sub_byte(w[15:8]), sub_byte(w[7:0]),
                sub_byte(w[31:24])};
    endfunction

    function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] n0, n1, n2, n3;
        n0 = k[127:96] ^ rot_sub(k[31:0], rc);
        n1 = k[95:64] ^ n0;
        n2 = k[63:32] ^ n1;
        n3 = k[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3;
        w3 = k[31:0] ^ k[63:32];
        w2 = k[63:32] ^ k[95:64];
        w1 = k[95:64] ^ k[127:96];
        w0 = k[127:96] ^ rot_sub(w3, rc);
        return {w0, w1, w2, w3};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/acd_key_stage.sv =====
`default_nettype none

module acd_key_stage #(
    parameter int unsigned RND = 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire acd_pkg::t_stage i_word,
    output logic                o_ready,
    output logic                o_valid,
    output acd_pkg::t_stage     o_word,
    input  wire logic           i_ready
);

    logic            r_valid;
    acd_pkg::t_stage r_word;
    acd_pkg::t_stage n_word;

    always_comb begin
        n_word      = i_word;
        n_word.rkey = acd_pkg::key_fwd(i_word.rkey, acd_pkg::RCON[RND]);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/acd_round_stage.sv =====
`default_nettype none

module acd_round_stage #(
    parameter int unsigned RND = 9
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire acd_pkg::t_stage i_word,
    output logic                o_ready,
    output logic                o_valid,
    output acd_pkg::t_stage     o_word,
    input  wire logic           i_ready
);

    logic            r_valid;
    acd_pkg::t_stage r_word;
    acd_pkg::t_stage n_word;
    logic [127:0]    key_prev;
    logic [127:0]    s_in;
    logic [127:0]    s_mid;

    always_comb begin
        key_prev     = acd_pkg::key_inv(i_word.rkey, acd_pkg::RCON[RND + 1]);
        s_in         = (RND == 9) ? (i_word.state ^ i_word.rkey) : i_word.state;
        s_mid        = acd_pkg::inv_shift_sub(s_in) ^ key_prev;
        n_word       = i_word;
        n_word.rkey  = key_prev;
        n_word.state = (RND == 0) ? s_mid : acd_pkg::inv_mix(s_mid);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/acd_out_stage.sv =====
`default_nettype none

module acd_out_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire acd_pkg::t_stage i_word,
    output logic                o_ready,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [63:0]         o_data_high,
    output logic [63:0]         o_data_low,
    output logic [4:0]          o_valid_bytes,
    output logic                o_end_of_packet,
    output logic [1:0]          o_status
);

    logic             r_valid;
    logic [127:0]     r_data;
    logic [4:0]       r_valid_bytes;
    logic             r_eop;
    acd_pkg::t_status r_status;

    logic [127:0]     n_data;
    logic [4:0]       n_valid_bytes;
    acd_pkg::t_status n_status;
    logic [127:0]     plain;
    logic [7:0]       pad;
    logic             pad_ok;

    always_comb begin
        plain  = i_word.state ^ i_word.side.prev;
        pad    = plain[7:0];
        pad_ok = (pad != 8'd0) && (pad <= 8'd16);
        for (int i = 0; i < 16; i++) begin
            if (({2'b00, 4'(i)} + {1'b0, pad[4:0]}) >= 6'd16 &&
                plain[127 - 8 * i -: 8] != pad) begin
                pad_ok = 1'b0;
            end
        end
        n_data        = plain;
        n_valid_bytes = 5'd16;
        n_status      = acd_pkg::ST_OK;
        if (i_word.side.no_cipher) begin
            n_data        = '0;
            n_valid_bytes = 5'd0;
            n_status      = acd_pkg::ST_NO_CIPHER;
        end else if (i_word.side.too_many) begin
            n_valid_bytes = 5'd0;
            n_status      = acd_pkg::ST_TOO_MANY;
        end else if (i_word.side.last) begin
            if (pad_ok) begin
                n_valid_bytes = 5'd16 - pad[4:0];
            end else begin
                n_valid_bytes = 5'd0;
                n_status      = acd_pkg::ST_BAD_PAD;
            end
        end
    end

    assign o_ready         = !r_valid || !i_stall;
    assign o_valid         = r_valid;
    assign o_data_high     = r_data[127:64];
    assign o_data_low      = r_data[63:0];
    assign o_valid_bytes   = r_valid_bytes;
    assign o_end_of_packet = r_eop;
    assign o_status        = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data        <= n_data;
            r_valid_bytes <= n_valid_bytes;
            r_eop         <= i_word.side.last;
            r_status      <= n_status;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/aes_cbc_decrypt_pkcs7.sv =====
// AES-128 CBC decryption with PKCS#7 pad check. A packet is an IV word (first_block)
// followed by ciphertext words; every ciphertext word yields one plaintext word, and a
// new word is taken every cycle unless the output stalls: the ten key-expansion stages
// and ten inverse-round stages form a pipeline with one round per stage, so the rate is
// one word per clock whatever the packet length. An IV word alone gives no result; an IV
// word that is also marked last gives a status of "no ciphertext". A nonzero status
// means drop the packet. Key writes apply to words accepted after the write.
`default_nettype none

module aes_cbc_decrypt_pkcs7 #(
    parameter int unsigned MAX_BLOCKS = 15
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_block_high,
    input  wire logic [63:0] i_block_low,
    input  wire logic        i_first_block,
    input  wire logic        i_last_block,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_data_high,
    output logic [63:0]      o_data_low,
    output logic [4:0]       o_valid_bytes,
    output logic             o_end_of_packet,
    output logic [1:0]       o_status
);

    localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 2);

    logic [63:0]      r_key_high;
    logic [63:0]      r_key_low;
    logic [127:0]     r_chain;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] cnt_inc;
    logic             accept;
    logic             too_many;

    acd_pkg::t_stage  w [0:20];
    logic             v [0:20];
    logic             rdy [0:20];

    assign accept = i_valid && !o_stall;
    assign o_stall = !rdy[0];

    always_comb begin
        cnt_inc  = (r_count <= CNT_W'(MAX_BLOCKS)) ? r_count + 1'b1 : r_count;
        too_many = cnt_inc > CNT_W'(MAX_BLOCKS);
        n_count  = (i_first_block || i_last_block) ? '0 : cnt_inc;
    end

    always_comb begin
        w[0].state          = {i_block_high, i_block_low};
        w[0].rkey           = {r_key_high, r_key_low};
        w[0].side.prev      = r_chain;
        w[0].side.last      = i_last_block;
        w[0].side.too_many  = too_many && !i_first_block;
        w[0].side.no_cipher = i_first_block;
        v[0]                = i_valid && (!i_first_block || i_last_block);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= 64'h0001020304050607;
            r_key_low  <= 64'h08090a0b0c0d0e0f;
            r_chain    <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == acd_pkg::CFG_KEY_HIGH) r_key_high <= i_cfg_data;
                else r_key_low <= i_cfg_data;
            end
            if (accept) begin
                r_chain <= {i_block_high, i_block_low};
                r_count <= n_count;
            end
        end
    end

    for (genvar k = 1; k <= 10; k++) begin : g_key
        acd_key_stage #(.RND(k)) u_key (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[k-1]),
            .i_word  (w[k-1]),
            .o_ready (rdy[k-1]),
            .o_valid (v[k]),
            .o_word  (w[k]),
            .i_ready (rdy[k])
        );
    end

    for (genvar j = 0; j < 10; j++) begin : g_round
        acd_round_stage #(.RND(9 - j)) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[10+j]),
            .i_word  (w[10+j]),
            .o_ready (rdy[10+j]),
            .o_valid (v[11+j]),
            .o_word  (w[11+j]),
            .i_ready (rdy[11+j])
        );
    end

    acd_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (v[20]),
        .i_word          (w[20]),
        .o_ready         (rdy[20]),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_data_high     (o_data_high),
        .o_data_low      (o_data_low),
        .o_valid_bytes   (o_valid_bytes),
        .o_end_of_packet (o_end_of_packet),
        .o_status        (o_status)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS + 1))
        else $error("block count out of range");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_block |=> r_count == '0)
        else $error("block count not cleared after last word");

    a_bad_status_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != acd_pkg::ST_OK |-> o_valid_bytes == 5'd0)
        else $error("nonzero status with kept bytes");

    a_no_cipher_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == acd_pkg::ST_NO_CIPHER |->
            o_data_high == 64'd0 && o_data_low == 64'd0 && o_end_of_packet)
        else $error("no-ciphertext result carries data");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_aes_cbc_decrypt_pkcs7.sv =====
`timescale 1ns / 1ps

module tb_aes_cbc_decrypt_pkcs7;

    localparam int CAP_BLOCKS = 15;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 30;

    localparam int BAD_NONE     = 0;
    localparam int BAD_ZERO_PAD = 1;
    localparam int BAD_BIG_PAD  = 2;
    localparam int BAD_PAD_BYTE = 3;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        first;
        logic        last;
    } t_word;

    typedef struct packed {
        logic [63:0]      hi;
        logic [63:0]      lo;
        logic [4:0]       nbytes;
        logic             eop;
        acd_pkg::t_status st;
    } t_plain;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [63:0] cfg_val = '0;
    logic        in_valid = 1'b0;
    logic [63:0] in_hi = '0;
    logic [63:0] in_lo = '0;
    logic        in_first = 1'b0;
    logic        in_last = 1'b0;
    logic        out_stall = 1'b0;
    wire         o_stall;
    wire         o_valid;
    wire  [63:0] o_data_high;
    wire  [63:0] o_data_low;
    wire  [4:0]  o_valid_bytes;
    wire         o_end_of_packet;
    wire  [1:0]  o_status;

    aes_cbc_decrypt_pkcs7 i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_we), .i_cfg_index(cfg_idx), .i_cfg_data(cfg_val),
        .i_valid(in_valid), .o_stall(o_stall),
        .i_block_high(in_hi), .i_block_low(in_lo),
        .i_first_block(in_first), .i_last_block(in_last),
        .o_valid(o_valid), .i_stall(out_stall),
        .o_data_high(o_data_high), .o_data_low(o_data_low),
        .o_valid_bytes(o_valid_bytes), .o_end_of_packet(o_end_of_packet),
        .o_status(o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [7:0]   sb [256];
    logic [7:0]   isb [256];
    logic [127:0] cur_key = 128'h000102030405060708090a0b0c0d0e0f;
    logic [127:0] chain = '0;
    int           ct_count = 0;
    t_word        pend [$];
    t_plain       plain_q [$];
    bit           failed = 0;
    bit           rst_done = 0;
    bit           idle_en = 1;
    bit           hold_req = 0;
    int           hold_cnt = 0;
    bit           word_took = 0;
    int           quiet = 0;
    int           made = 0;

    function automatic logic [7:0] gm(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] a);
        logic [7:0] r;
        r = 1;
        for (int i = 0; i < 254; i++) r = gm(r, a);
        return r;
    endfunction

    function automatic logic [7:0] rl(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [127:0] unround(input logic [127:0] s);
        logic [127:0] o;
        o = '0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                o[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8] = isb[s[127 - 8 * (r + 4 * c) -: 8]];
        return o;
    endfunction

    function automatic logic [127:0] unmix(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            o[127 - 32 * c -: 8] = gm(a0, 14) ^ gm(a1, 11) ^ gm(a2, 13) ^ gm(a3, 9);
            o[119 - 32 * c -: 8] = gm(a0, 9) ^ gm(a1, 14) ^ gm(a2, 11) ^ gm(a3, 13);
            o[111 - 32 * c -: 8] = gm(a0, 13) ^ gm(a1, 9) ^ gm(a2, 14) ^ gm(a3, 11);
            o[103 - 32 * c -: 8] = gm(a0, 11) ^ gm(a1, 13) ^ gm(a2, 9) ^ gm(a3, 14);
        end
        return o;
    endfunction

    function automatic logic [127:0] aes_dec(input logic [127:0] ct, input logic [127:0] key);
        logic [31:0]  w [44];
        logic [31:0]  t;
        logic [7:0]   rc;
        logic [127:0] s;
        rc = 1;
        for (int i = 0; i < 4; i++) w[i] = key[127 - 32 * i -: 32];
        for (int i = 4; i < 44; i++) begin
            t = w[i - 1];
            if (i % 4 == 0) begin
                t = {sb[t[23:16]] ^ rc, sb[t[15:8]], sb[t[7:0]], sb[t[31:24]]};
                rc = gm(rc, 2);
            end
            w[i] = w[i - 4] ^ t;
        end
        s = ct ^ {w[40], w[41], w[42], w[43]};
        for (int rnd = 9; rnd >= 1; rnd--)
            s = unmix(unround(s) ^ {w[4 * rnd], w[4 * rnd + 1], w[4 * rnd + 2], w[4 * rnd + 3]});
        return unround(s) ^ {w[0], w[1], w[2], w[3]};
    endfunction

    function automatic void predict_plain(input t_word wd);
        t_plain p;
        logic [127:0] blk, pt;
        logic [7:0] pad;
        bit ok;
        blk = {wd.hi, wd.lo};
        if (wd.first) begin
            chain = blk;
            ct_count = 0;
            if (wd.last) begin
                p = '{64'd0, 64'd0, 5'd0, 1'b1, acd_pkg::ST_NO_CIPHER};
                plain_q.push_back(p);
            end
            return;
        end
        pt = aes_dec(blk, cur_key) ^ chain;
        chain = blk;
        if (ct_count <= CAP_BLOCKS) ct_count++;
        p.hi = pt[127:64];
        p.lo = pt[63:0];
        p.nbytes = 5'd16;
        p.eop = wd.last;
        p.st = acd_pkg::ST_OK;
        if (ct_count > CAP_BLOCKS) begin
            p.st = acd_pkg::ST_TOO_MANY;
            p.nbytes = 5'd0;
        end else if (wd.last) begin
            pad = pt[7:0];
            ok = pad != 0 && pad <= 16;
            if (ok)
                for (int i = 16 - pad; i < 16; i++)
                    if (pt[127 - 8 * i -: 8] != pad) ok = 0;
            if (ok) begin
                p.nbytes = 5'(16 - pad);
            end else begin
                p.st = acd_pkg::ST_BAD_PAD;
                p.nbytes = 5'd0;
            end
        end
        if (wd.last) ct_count = 0;
        plain_q.push_back(p);
    endfunction

    task automatic push_word(input logic [127:0] b, input bit f, input bit l);
        t_word wd;
        wd = '{b[127:64], b[63:0], f, l};
        pend.push_back(wd);
        made++;
    endtask

    task automatic push_packet(input int n, input int pad, input int bad);
        logic [127:0] pk [0:17];
        logic [127:0] pt;
        int k;
        pt = {$urandom, $urandom, $urandom, $urandom};
        for (int i = 16 - pad; i < 16; i++) pt[127 - 8 * i -: 8] = pad;
        if (bad == BAD_PAD_BYTE && pad < 2) bad = BAD_ZERO_PAD;
        case (bad)
            BAD_ZERO_PAD: pt[7:0] = 8'd0;
            BAD_BIG_PAD: pt[7:0] = $urandom_range(17, 255);
            BAD_PAD_BYTE: begin
                k = 16 - pad + $urandom_range(0, pad - 2);
                pt[127 - 8 * k -: 8] ^= $urandom_range(1, 255);
            end
            default: ;
        endcase
        for (int i = 0; i <= n; i++) pk[i] = {$urandom, $urandom, $urandom, $urandom};
        pk[n - 1] = aes_dec(pk[n], cur_key) ^ pt;
        for (int i = 0; i <= n; i++) push_word(pk[i], i == 0, i == n);
    endtask

    task automatic wait_drained();
        while (pend.size() != 0 || plain_q.size() != 0 || in_valid) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_key(input logic [127:0] key);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= acd_pkg::CFG_KEY_HIGH;
        cfg_val <= key[127:64];
        @(negedge i_clk);
        cfg_idx <= acd_pkg::CFG_KEY_LOW;
        cfg_val <= key[63:0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cur_key = key;
    endtask

    task automatic random_words(input int target);
        int r, n;
        made = 0;
        while (made < target) begin
            r = $urandom_range(0, 99);
            if (r < 78) begin
                n = ($urandom_range(0, 99) < 8) ? $urandom_range(13, 17) : $urandom_range(1, 4);
                push_packet(n, $urandom_range(1, 16),
                            ($urandom_range(0, 99) < 20) ?
                                $urandom_range(BAD_ZERO_PAD, BAD_PAD_BYTE) : BAD_NONE);
            end else begin
                push_word({$urandom, $urandom, $urandom, $urandom},
                          $urandom_range(0, 1), $urandom_range(0, 1));
            end
        end
    endtask

    always @(negedge i_clk) begin
        t_word wd;
        logic v;
        v = in_valid;
        if (rst_done && (!in_valid || word_took)) begin
            v = 1'b0;
            if (pend.size() != 0 && !(idle_en && $urandom_range(0, 99) < 30)) begin
                wd = pend.pop_front();
                in_hi <= wd.hi;
                in_lo <= wd.lo;
                in_first <= wd.first;
                in_last <= wd.last;
                v = 1'b1;
            end
        end
        in_valid <= v;
    end

    always @(negedge i_clk) begin
        if (hold_req && hold_cnt == 0) begin
            hold_cnt = 400;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= idle_en && ($urandom_range(0, 99) < 30);
        end
    end

    always @(posedge i_clk) begin
        t_word wd;
        t_plain got, want;
        word_took = in_valid && !o_stall;
        if (word_took) begin
            wd = '{in_hi, in_lo, in_first, in_last};
            predict_plain(wd);
        end
        if (i_rst_n && o_valid && !out_stall) begin
            got = '{o_data_high, o_data_low, o_valid_bytes, o_end_of_packet,
                    acd_pkg::t_status'(o_status)};
            if (plain_q.size() == 0) begin
                $display("%t unexpected word: %h %h bytes %0d eop %0b st %0d", $realtime,
                         got.hi, got.lo, got.nbytes, got.eop, got.st);
                failed = 1;
            end else begin
                want = plain_q.pop_front();
                if (got != want) begin
                    $display("%t mismatch exp %h %h bytes %0d eop %0b st %0d", $realtime,
                             want.hi, want.lo, want.nbytes, want.eop, want.st);
                    $display("%t          act %h %h bytes %0d eop %0b st %0d", $realtime,
                             got.hi, got.lo, got.nbytes, got.eop, got.st);
                    failed = 1;
                end
            end
        end
        if (word_took || (o_valid && !out_stall) || cfg_we || !rst_done) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("%t timeout, %0d words outstanding", $realtime, plain_q.size());
            $display("[aes_cbc_decrypt_pkcs7] ERROR");
            $finish;
        end
    end

    initial begin
        logic [127:0] keys [4];
        for (int x = 0; x < 256; x++) begin
            logic [7:0] v;
            v = ginv(x);
            sb[x] = v ^ rl(v, 1) ^ rl(v, 2) ^ rl(v, 3) ^ rl(v, 4) ^ 8'h63;
        end
        for (int x = 0; x < 256; x++) isb[sb[x]] = x;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        rst_done = 1;

        // ciphertext before any IV chains on zero
        push_word('0, 0, 0);
        push_word('1, 0, 0);
        push_word({$urandom, $urandom, $urandom, $urandom}, 1, 1);
        push_packet(1, 16, BAD_NONE);
        push_packet(1, 1, BAD_NONE);
        push_packet(1, 4, BAD_ZERO_PAD);
        push_packet(1, 3, BAD_BIG_PAD);
        push_packet(2, 9, BAD_PAD_BYTE);
        push_word('1, 1, 0);
        push_word('1, 0, 1);
        push_word('0, 1, 0);
        push_word('0, 0, 1);
        push_packet(1, 7, BAD_NONE);
        wait_drained();

        keys[0] = '0;
        keys[1] = '1;
        keys[2] = {$urandom, $urandom, $urandom, $urandom};
        keys[3] = 128'h000102030405060708090a0b0c0d0e0f;
        for (int ph = 0; ph < 4; ph++) begin
            write_key(keys[ph]);
            idle_en = (ph != 1);
            if (ph == 2) hold_req = 1;
            random_words(480);
            wait_drained();
        end
        idle_en = 1;

        if (!failed) begin
            $display("[aes_cbc_decrypt_pkcs7] OK");
        end else begin
            $display("[aes_cbc_decrypt_pkcs7] ERROR");
        end
        $finish;
    end

endmodule

// ===== aes_cbc_decrypt_pkcs7.f =====
rtl/core/acd_pkg.sv
rtl/core/acd_key_stage.sv
rtl/core/acd_round_stage.sv
rtl/core/acd_out_stage.sv
rtl/core/aes_cbc_decrypt_pkcs7.sv
sim/tb_aes_cbc_decrypt_pkcs7.sv
